// ===== src/tmjc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmjc_pkg
// Shared types and constants for the thresholded jet colormap block.
// ----------------------------------------------------------------------------
package tmjc_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_NONE   = 2'd3
  } tmjc_cmd_t;

  // Stage-one control as seen by the datapath units
  typedef struct packed {
    logic      fire;
    tmjc_cmd_t cmd;
  } tmjc_ctl_t;

  localparam int unsigned THR_W      = 10;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned ENTRY_W    = 3 * COLOR_W;
  localparam int unsigned PROD_W     = 27;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [THR_W-1:0]          THR_RESET  = 10'd29;
  localparam logic signed [LEVEL_W-1:0] MAX_RESET  = 16'sh8000;
  localparam logic signed [10:0]        THR_SCALE  = 11'sd1000;

  // Register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

endpackage

// ===== src/threshold_masked_jet_colormap.sv =====
// ----------------------------------------------------------------------------
// threshold_masked_jet_colormap
// Colormap write, frame maximum pass and masked jet rendering, one
// transaction per cycle while the result is not stalled.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    cmd, lut_*, intensity, slope,
//                                              frame_start
//   out_     output     out_valid / out_stall  blue, green, red, visible
//   cfg_     APB slave  psel/penable/pready    threshold_thousandths @ 0x0
//
// One transaction per cycle sustained while the result is not stalled.
// From input acceptance the path runs through an input register, then the
// colormap read and the threshold compare land in the result register.
// Reset (rst_n low, synchronous) empties both stages, sets the maximum to
// -32768 and the threshold to 29; the colormap is not cleared.
// A stalled result holds stage two; stage one drains writes and samples
// behind it only once the result is taken.
// ----------------------------------------------------------------------------
module threshold_masked_jet_colormap import tmjc_pkg::*; #(
  parameter int SLOPE_LEVELS = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [7:0]                in_lut_index,
  input  logic [COLOR_W-1:0]        in_lut_blue,
  input  logic [COLOR_W-1:0]        in_lut_green,
  input  logic [COLOR_W-1:0]        in_lut_red,
  input  logic signed [LEVEL_W-1:0] in_intensity,
  input  logic signed [LEVEL_W-1:0] in_slope,
  input  logic                      in_frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COLOR_W-1:0]        out_blue,
  output logic [COLOR_W-1:0]        out_green,
  output logic [COLOR_W-1:0]        out_red,
  output logic                      out_visible,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]     cfg_paddr,
  input  logic [APB_DATA_W-1:0]     cfg_pwdata,
  output logic [APB_DATA_W-1:0]     cfg_prdata,
  output logic                      cfg_pready
);

  // Stage one: input register
  logic                      s1_valid_r, s1_valid_nxt;
  tmjc_cmd_t                 s1_cmd_r;
  logic [7:0]                s1_index_r;
  logic [ENTRY_W-1:0]        s1_entry_r;
  logic signed [LEVEL_W-1:0] s1_level_r;
  logic signed [LEVEL_W-1:0] s1_slope_r;
  logic                      s1_start_r;

  logic                      out_valid_r, out_valid_nxt;
  logic                      s2_free;
  logic                      in_take;
  logic                      visible_r;
  logic [ENTRY_W-1:0]        rd_entry_r;
  logic [THR_W-1:0]          thr_r;
  tmjc_ctl_t                 ctl;

  assign s2_free  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  assign ctl.fire = s1_valid_r && s2_free;
  assign ctl.cmd  = s1_cmd_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s2_free || !s1_valid_r) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_free) begin
      out_valid_nxt = s1_valid_r && s1_cmd_r == CMD_RENDER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r   <= tmjc_cmd_t'(in_cmd);
      s1_index_r <= in_lut_index;
      s1_entry_r <= {in_lut_red, in_lut_green, in_lut_blue};
      s1_level_r <= in_intensity;
      s1_slope_r <= in_slope;
      s1_start_r <= in_frame_start;
    end
  end

  tmjc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .thr_r   (thr_r)
  );

  tmjc_lut #(
    .SLOPE_LEVELS (SLOPE_LEVELS)
  ) u_lut (
    .clk        (clk),
    .ctl        (ctl),
    .wr_index   (s1_index_r),
    .wr_entry   (s1_entry_r),
    .slope      (s1_slope_r),
    .rd_entry_r (rd_entry_r)
  );

  tmjc_thr u_thr (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .level       (s1_level_r),
    .frame_start (s1_start_r),
    .thr         (thr_r),
    .visible_r   (visible_r)
  );

  assign out_valid   = out_valid_r;
  assign out_visible = visible_r;
  assign out_blue    = visible_r ? rd_entry_r[COLOR_W-1:0]           : '0;
  assign out_green   = visible_r ? rd_entry_r[2*COLOR_W-1:COLOR_W]   : '0;
  assign out_red     = visible_r ? rd_entry_r[3*COLOR_W-1:2*COLOR_W] : '0;

  a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && s1_cmd_r == CMD_RENDER |=> out_valid)
    else $error("render transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    s2_free && !(s1_valid_r && s1_cmd_r == CMD_RENDER) |=> !out_valid)
    else $error("result raised without a render transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled while the pipeline could advance");

endmodule

// ===== src/tmjc_cfg.sv =====
// ----------------------------------------------------------------------------
// tmjc_cfg
// APB register file holding the relative visibility threshold.
// ----------------------------------------------------------------------------
module tmjc_cfg import tmjc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [THR_W-1:0]      thr_r
);

  logic             wr_en;
  logic [THR_W-1:0] thr_nxt;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_THRESHOLD);

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      thr_nxt = pwdata[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_THRESHOLD) begin
      prdata = {{(APB_DATA_W-THR_W){1'b0}}, thr_r};
    end
  end

endmodule

// ===== src/tmjc_lut.sv =====
// ----------------------------------------------------------------------------
// tmjc_lut
// Slope to colour index mapping and the 256-entry colormap memory.
// ----------------------------------------------------------------------------
module tmjc_lut import tmjc_pkg::*; #(
  parameter int SLOPE_LEVELS = 5
) (
  input  logic                      clk,
  input  tmjc_ctl_t                 ctl,
  input  logic [7:0]                wr_index,
  input  logic [ENTRY_W-1:0]        wr_entry,
  input  logic signed [LEVEL_W-1:0] slope,
  output logic [ENTRY_W-1:0]        rd_entry_r
);

  localparam logic signed [LEVEL_W-1:0] LEVELS_S = LEVEL_W'(SLOPE_LEVELS);

  logic [ENTRY_W-1:0] mem [256];
  logic [7:0]         idx_tbl [256];
  logic [7:0]         rd_index;

  // floor(255*s/L) for 0 < s < L; entries at or above L are never read
  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign idx_tbl[i] = 8'((i * 255) / SLOPE_LEVELS);
  end

  always_comb begin
    priority if (slope <= 0) begin
      rd_index = 8'd0;
    end else if (slope >= LEVELS_S) begin
      rd_index = 8'd255;
    end else begin
      rd_index = idx_tbl[slope[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.cmd == CMD_WRITE) begin
      mem[wr_index] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.cmd == CMD_RENDER) begin
      rd_entry_r <= mem[rd_index];
    end
  end

endmodule

// ===== src/tmjc_thr.sv =====
// ----------------------------------------------------------------------------
// tmjc_thr
// Running frame maximum and the relative threshold visibility test.
// ----------------------------------------------------------------------------
module tmjc_thr import tmjc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tmjc_ctl_t                 ctl,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic                      frame_start,
  input  logic [THR_W-1:0]          thr,
  output logic                      visible_r
);

  logic signed [LEVEL_W-1:0] frame_max_r, frame_max_nxt;
  logic signed [PROD_W-1:0]  lhs, rhs;
  logic signed [THR_W:0]     thr_s;
  logic                      pass;

  assign thr_s = $signed({1'b0, thr});
  assign lhs   = level * THR_SCALE;
  assign rhs   = thr_s * frame_max_r;

  // Test flips for a negative maximum; a zero maximum only needs a positive level
  always_comb begin
    priority if (frame_max_r > 0) begin
      pass = lhs > rhs;
    end else if (frame_max_r < 0) begin
      pass = lhs < rhs;
    end else begin
      pass = level > 0;
    end
  end

  always_comb begin
    frame_max_nxt = frame_max_r;
    if (ctl.fire && ctl.cmd == CMD_SAMPLE && (frame_start || level > frame_max_r)) begin
      frame_max_nxt = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_max_r <= MAX_RESET;
    end else begin
      frame_max_r <= frame_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.cmd == CMD_RENDER) begin
      visible_r <= pass;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.fire && ctl.cmd == CMD_SAMPLE && frame_start |=> frame_max_r == $past(level))
    else $error("frame maximum not restarted by a frame start sample");

  a_max_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.fire && ctl.cmd == CMD_SAMPLE) |=> $stable(frame_max_r))
    else $error("frame maximum changed outside a sample transaction");

endmodule
